/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define PDTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define PDTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pdte_pkg.sv */
// Types, constants and micro-op table for the twist estimator.
`timescale 1ns / 1ps
`default_nettype none
package pdte_pkg;

    localparam int POS_W     = 32;
    localparam int QUAT_W    = 16;
    localparam int STAMP_W   = 48;
    localparam int MIN_W     = 20;
    localparam int VEL_W     = 32;
    localparam int OPD_W     = 36;
    localparam int PROD_W    = 2 * OPD_W;
    localparam int ACC_W     = 110;
    localparam int ROT_W     = 34;
    localparam int DQ_W      = 34;
    localparam int DPOS_W    = POS_W + 1;
    localparam int BV_W      = 69;
    localparam int SPLIT     = 34;
    localparam int DEN_W     = STAMP_W + 28;
    localparam int LIN_SHIFT = 28;
    localparam int ANG_SHIFT = 12;
    localparam int QUO_W     = 32;
    localparam int CNT_W     = 6;
    localparam int STEP_W    = 6;
    localparam int N_OUT     = 6;
    localparam int K_W       = 3;

    localparam logic [MIN_W-1:0]         MIN_RESET = 20'd1000;
    localparam logic signed [QUAT_W-1:0] Q_ONE     = 16'sd16384;
    localparam logic [OPD_W-1:0]         K_LIN     = 36'd1000000000;
    localparam logic [OPD_W-1:0]         K_ANG     = 36'd2000000000;
    localparam logic [STEP_W-1:0]        STEP_LAST = 6'd46;
    localparam logic [VEL_W-1:0]         VEL_MAX   = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0]         VEL_MIN   = 32'h8000_0000;

    typedef enum logic [4:0] {
        A_ZERO, A_ONE, A_2X, A_2Y, A_2Z, A_QW, A_QX, A_QY, A_QZ,
        A_R00, A_R01, A_R02, A_R10, A_R11, A_R12, A_R20, A_R21, A_R22
    } t_asel;

    typedef enum logic [3:0] {
        B_ZERO, B_ONE, B_W, B_X, B_Y, B_Z, B_D0, B_D1, B_D2
    } t_bsel;

    typedef enum logic [4:0] {
        D_NONE, D_R00, D_R01, D_R02, D_R10, D_R11, D_R12, D_R20, D_R21, D_R22,
        D_DQ0, D_DQ1, D_DQ2, D_DQ3, D_B0, D_B1, D_B2
    } t_dst;

    typedef struct packed {
        logic  clr;
        logic  sub;
        t_asel asel;
        t_bsel bsel;
        t_dst  dst;
    } t_uop;

    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
        logic hi;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic t_uop mk(input logic c, input logic s, input t_asel a,
                                input t_bsel b, input t_dst d);
        t_uop u;
        u.clr  = c;
        u.sub  = s;
        u.asel = a;
        u.bsel = b;
        u.dst  = d;
        return u;
    endfunction

    // Rotation matrix, delta quaternion and body-frame offset, one product per step.
    function automatic t_uop uop(input logic [STEP_W-1:0] s);
        t_uop u;
        unique case (s)
            6'd0:  u = mk(1'b1, 1'b0, A_ONE, B_ONE, D_NONE);
            6'd1:  u = mk(1'b0, 1'b1, A_2Y,  B_Y,   D_NONE);
            6'd2:  u = mk(1'b0, 1'b1, A_2Z,  B_Z,   D_NONE);
            6'd3:  u = mk(1'b1, 1'b0, A_2X,  B_Y,   D_R00);
            6'd4:  u = mk(1'b0, 1'b1, A_2Z,  B_W,   D_NONE);
            6'd5:  u = mk(1'b1, 1'b0, A_2X,  B_Z,   D_R01);
            6'd6:  u = mk(1'b0, 1'b0, A_2Y,  B_W,   D_NONE);
            6'd7:  u = mk(1'b1, 1'b0, A_2X,  B_Y,   D_R02);
            6'd8:  u = mk(1'b0, 1'b0, A_2Z,  B_W,   D_NONE);
            6'd9:  u = mk(1'b1, 1'b0, A_ONE, B_ONE, D_R10);
            6'd10: u = mk(1'b0, 1'b1, A_2X,  B_X,   D_NONE);
            6'd11: u = mk(1'b0, 1'b1, A_2Z,  B_Z,   D_NONE);
            6'd12: u = mk(1'b1, 1'b0, A_2Y,  B_Z,   D_R11);
            6'd13: u = mk(1'b0, 1'b1, A_2X,  B_W,   D_NONE);
            6'd14: u = mk(1'b1, 1'b0, A_2X,  B_Z,   D_R12);
            6'd15: u = mk(1'b0, 1'b1, A_2Y,  B_W,   D_NONE);
            6'd16: u = mk(1'b1, 1'b0, A_2Y,  B_Z,   D_R20);
            6'd17: u = mk(1'b0, 1'b0, A_2X,  B_W,   D_NONE);
            6'd18: u = mk(1'b1, 1'b0, A_ONE, B_ONE, D_R21);
            6'd19: u = mk(1'b0, 1'b1, A_2X,  B_X,   D_NONE);
            6'd20: u = mk(1'b0, 1'b1, A_2Y,  B_Y,   D_NONE);
            6'd21: u = mk(1'b1, 1'b0, A_QW,  B_W,   D_R22);
            6'd22: u = mk(1'b0, 1'b0, A_QX,  B_X,   D_NONE);
            6'd23: u = mk(1'b0, 1'b0, A_QY,  B_Y,   D_NONE);
            6'd24: u = mk(1'b0, 1'b0, A_QZ,  B_Z,   D_NONE);
            6'd25: u = mk(1'b1, 1'b1, A_QX,  B_W,   D_DQ0);
            6'd26: u = mk(1'b0, 1'b0, A_QW,  B_X,   D_NONE);
            6'd27: u = mk(1'b0, 1'b1, A_QZ,  B_Y,   D_NONE);
            6'd28: u = mk(1'b0, 1'b0, A_QY,  B_Z,   D_NONE);
            6'd29: u = mk(1'b1, 1'b1, A_QY,  B_W,   D_DQ1);
            6'd30: u = mk(1'b0, 1'b0, A_QZ,  B_X,   D_NONE);
            6'd31: u = mk(1'b0, 1'b0, A_QW,  B_Y,   D_NONE);
            6'd32: u = mk(1'b0, 1'b1, A_QX,  B_Z,   D_NONE);
            6'd33: u = mk(1'b1, 1'b1, A_QZ,  B_W,   D_DQ2);
            6'd34: u = mk(1'b0, 1'b1, A_QY,  B_X,   D_NONE);
            6'd35: u = mk(1'b0, 1'b0, A_QX,  B_Y,   D_NONE);
            6'd36: u = mk(1'b0, 1'b0, A_QW,  B_Z,   D_NONE);
            6'd37: u = mk(1'b1, 1'b0, A_R00, B_D0,  D_DQ3);
            6'd38: u = mk(1'b0, 1'b0, A_R10, B_D1,  D_NONE);
            6'd39: u = mk(1'b0, 1'b0, A_R20, B_D2,  D_NONE);
            6'd40: u = mk(1'b1, 1'b0, A_R01, B_D0,  D_B0);
            6'd41: u = mk(1'b0, 1'b0, A_R11, B_D1,  D_NONE);
            6'd42: u = mk(1'b0, 1'b0, A_R21, B_D2,  D_NONE);
            6'd43: u = mk(1'b1, 1'b0, A_R02, B_D0,  D_B1);
            6'd44: u = mk(1'b0, 1'b0, A_R12, B_D1,  D_NONE);
            6'd45: u = mk(1'b0, 1'b0, A_R22, B_D2,  D_NONE);
            6'd46: u = mk(1'b1, 1'b0, A_ZERO, B_ZERO, D_B2);
            default: u = mk(1'b1, 1'b0, A_ZERO, B_ZERO, D_NONE);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

/* sv/pdte_mac.sv */
// Shared signed multiply-accumulate unit.
`timescale 1ns / 1ps
`default_nettype none
module pdte_mac (
    input  wire logic                                i_clk,
    input  wire pdte_pkg::t_mac_ctl                  i_ctl,
    input  wire logic signed [pdte_pkg::OPD_W-1:0]   i_a,
    input  wire logic signed [pdte_pkg::OPD_W-1:0]   i_b,
    output logic signed [pdte_pkg::ACC_W-1:0]        o_acc
);

    logic signed [pdte_pkg::ACC_W-1:0]  r_acc;
    logic signed [pdte_pkg::ACC_W-1:0]  n_acc;
    logic signed [pdte_pkg::PROD_W-1:0] prod;
    logic signed [pdte_pkg::ACC_W-1:0]  term;
    logic signed [pdte_pkg::ACC_W-1:0]  base;

    always_comb begin
        prod = i_a * i_b;
        term = pdte_pkg::ACC_W'(prod);
        if (i_ctl.hi) begin
            term = term <<< pdte_pkg::SPLIT;
        end
        base  = i_ctl.clr ? '0 : r_acc;
        n_acc = i_ctl.sub ? base - term : base + term;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

/* sv/pdte_div.sv */
// Restoring divider with rounding and 32-bit saturation, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pdte_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [pdte_pkg::ACC_W-1:0]         i_num,
    input  wire logic [pdte_pkg::DEN_W-1:0]         i_den,
    input  wire logic                               i_neg,
    output pdte_pkg::t_div_sts                      o_sts,
    output logic [pdte_pkg::VEL_W-1:0]              o_res
);

    logic [pdte_pkg::ACC_W-1:0] r_rem;
    logic [pdte_pkg::ACC_W-1:0] r_dsh;
    logic [pdte_pkg::QUO_W-1:0] r_q;
    logic [pdte_pkg::CNT_W-1:0] r_cnt;
    logic                       r_ovf;
    logic                       r_neg;
    logic                       r_busy;
    logic                       r_done;
    logic                       ge;

    assign ge = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num + pdte_pkg::ACC_W'(i_den >> 1);
                r_dsh  <= pdte_pkg::ACC_W'(i_den) << pdte_pkg::QUO_W;
                r_cnt  <= pdte_pkg::CNT_W'(pdte_pkg::QUO_W);
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_neg  <= i_neg;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                if (r_cnt == pdte_pkg::CNT_W'(pdte_pkg::QUO_W)) begin
                    r_ovf <= ge;
                end else begin
                    r_q <= {r_q[pdte_pkg::QUO_W-2:0], ge};
                end
                r_dsh <= r_dsh >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_ovf) begin
            o_res = r_neg ? pdte_pkg::VEL_MIN : pdte_pkg::VEL_MAX;
        end else if (r_neg) begin
            o_res = (r_q > pdte_pkg::VEL_MIN) ? pdte_pkg::VEL_MIN : (~r_q + 1'b1);
        end else begin
            o_res = r_q[pdte_pkg::QUO_W-1] ? pdte_pkg::VEL_MAX : r_q;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule
`default_nettype wire

/* sv/pose_difference_twist_estimator.sv */
// Top level: pose-difference twist estimator with shared MAC and divider.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------------
//  in       | i_in_valid / o_in_ready        | i_pos_*, i_quat_*, i_stamp_ns
//  out      | o_out_valid / i_out_ready      | o_lin_vel_*, o_ang_vel_*, o_twist_valid
//  config   | psel penable pwrite / pready   | paddr, pwdata, prdata
//
// A computed twist passes through the accept, 47 MAC steps, then per velocity two
// scaling MAC steps, a divider start and the bit-serial divider, then the output
// state S_OUT. A sample with no twist goes from the accept straight to S_OUT.
// One item in flight at a time. A new item is taken while the output register waits;
// its own result then holds in S_OUT until the output register is free.
// Reset is synchronous; it restores the identity pose and min_interval_ns 1000.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pose_difference_twist_estimator (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [pdte_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic signed [pdte_pkg::POS_W-1:0]    i_pos_y,
    input  wire logic signed [pdte_pkg::POS_W-1:0]    i_pos_z,
    input  wire logic signed [pdte_pkg::QUAT_W-1:0]   i_quat_w,
    input  wire logic signed [pdte_pkg::QUAT_W-1:0]   i_quat_x,
    input  wire logic signed [pdte_pkg::QUAT_W-1:0]   i_quat_y,
    input  wire logic signed [pdte_pkg::QUAT_W-1:0]   i_quat_z,
    input  wire logic [pdte_pkg::STAMP_W-1:0]         i_stamp_ns,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [pdte_pkg::VEL_W-1:0]         o_lin_vel_x,
    output logic signed [pdte_pkg::VEL_W-1:0]         o_lin_vel_y,
    output logic signed [pdte_pkg::VEL_W-1:0]         o_lin_vel_z,
    output logic signed [pdte_pkg::VEL_W-1:0]         o_ang_vel_x,
    output logic signed [pdte_pkg::VEL_W-1:0]         o_ang_vel_y,
    output logic signed [pdte_pkg::VEL_W-1:0]         o_ang_vel_z,
    output logic                                      o_twist_valid,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_SCL_LO, S_SCL_HI, S_DIV_GO, S_DIV_WAIT, S_OUT
    } t_state;

    t_state r_state;

    logic [pdte_pkg::MIN_W-1:0]          r_min;
    logic signed [pdte_pkg::POS_W-1:0]   r_last_pos [3];
    logic signed [pdte_pkg::QUAT_W-1:0]  r_last_q [4];
    logic [pdte_pkg::STAMP_W-1:0]        r_last_stamp;
    logic                                r_have_prev;

    logic signed [pdte_pkg::POS_W-1:0]   r_pos [3];
    logic signed [pdte_pkg::QUAT_W-1:0]  r_q [4];
    logic [pdte_pkg::STAMP_W-1:0]        r_stamp;
    logic [pdte_pkg::STAMP_W-1:0]        r_dt;
    logic                                r_ok;

    logic [pdte_pkg::STEP_W-1:0]         r_step;
    logic [pdte_pkg::K_W-1:0]            r_k;
    logic signed [pdte_pkg::ROT_W-1:0]   r_rot [9];
    logic signed [pdte_pkg::DQ_W-1:0]    r_dq [4];
    logic signed [pdte_pkg::BV_W-1:0]    r_bv [3];
    logic [pdte_pkg::VEL_W-1:0]          r_res [pdte_pkg::N_OUT];

    logic                                r_out_valid;
    logic                                r_out_tw;
    logic [pdte_pkg::VEL_W-1:0]          r_out [pdte_pkg::N_OUT];

    logic [pdte_pkg::STAMP_W-1:0]        dt_in;
    logic                                ok_in;
    logic                                in_acc;
    logic                                cfg_wr;
    pdte_pkg::t_uop                      u;
    pdte_pkg::t_mac_ctl                  mac_ctl;
    logic signed [pdte_pkg::OPD_W-1:0]   op_a;
    logic signed [pdte_pkg::OPD_W-1:0]   op_b;
    logic signed [pdte_pkg::ACC_W-1:0]   acc;
    logic signed [pdte_pkg::DPOS_W-1:0]  d [3];
    logic signed [pdte_pkg::BV_W-1:0]    sel_v;
    logic                                sel_neg;
    logic [pdte_pkg::BV_W-1:0]           sel_mag;
    logic [pdte_pkg::OPD_W-1:0]          sel_k;
    logic [pdte_pkg::DEN_W-1:0]          sel_den;
    logic                                flip;
    logic                                div_start;
    pdte_pkg::t_div_sts                  div_sts;
    logic [pdte_pkg::VEL_W-1:0]          div_res;
    logic                                vel_bad;

    assign dt_in  = i_stamp_ns - r_last_stamp;
    assign ok_in  = r_have_prev && (i_stamp_ns > r_last_stamp)
                    && (dt_in > pdte_pkg::STAMP_W'(r_min));
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc = i_in_valid && o_in_ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = 32'(r_min);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i] = pdte_pkg::DPOS_W'(r_pos[i]) - pdte_pkg::DPOS_W'(r_last_pos[i]);
        end
    end

    assign u    = pdte_pkg::uop(r_step);
    assign flip = r_dq[0][pdte_pkg::DQ_W-1];

    always_comb begin
        unique case (r_k)
            3'd0: sel_v = r_bv[0];
            3'd1: sel_v = r_bv[1];
            3'd2: sel_v = r_bv[2];
            3'd3: sel_v = pdte_pkg::BV_W'(r_dq[1]);
            3'd4: sel_v = pdte_pkg::BV_W'(r_dq[2]);
            3'd5: sel_v = pdte_pkg::BV_W'(r_dq[3]);
            default: sel_v = '0;
        endcase
        sel_mag = sel_v[pdte_pkg::BV_W-1] ? pdte_pkg::BV_W'(-sel_v) : sel_v;
        if (r_k < 3'd3) begin
            sel_neg = sel_v[pdte_pkg::BV_W-1];
            sel_k   = pdte_pkg::K_LIN;
            sel_den = pdte_pkg::DEN_W'({r_dt, pdte_pkg::LIN_SHIFT'(0)});
        end else begin
            sel_neg = flip ? (sel_v > 0) : (sel_v < 0);
            sel_k   = pdte_pkg::K_ANG;
            sel_den = pdte_pkg::DEN_W'({r_dt, pdte_pkg::ANG_SHIFT'(0)});
        end
    end

    always_comb begin
        mac_ctl = '0;
        op_a    = '0;
        op_b    = '0;
        unique case (r_state)
            S_RUN: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = u.clr;
                mac_ctl.sub = u.sub;
                unique case (u.asel)
                    pdte_pkg::A_ZERO: op_a = '0;
                    pdte_pkg::A_ONE:  op_a = pdte_pkg::OPD_W'(pdte_pkg::Q_ONE);
                    pdte_pkg::A_2X:   op_a = pdte_pkg::OPD_W'(r_q[1]) <<< 1;
                    pdte_pkg::A_2Y:   op_a = pdte_pkg::OPD_W'(r_q[2]) <<< 1;
                    pdte_pkg::A_2Z:   op_a = pdte_pkg::OPD_W'(r_q[3]) <<< 1;
                    pdte_pkg::A_QW:   op_a = pdte_pkg::OPD_W'(r_last_q[0]);
                    pdte_pkg::A_QX:   op_a = pdte_pkg::OPD_W'(r_last_q[1]);
                    pdte_pkg::A_QY:   op_a = pdte_pkg::OPD_W'(r_last_q[2]);
                    pdte_pkg::A_QZ:   op_a = pdte_pkg::OPD_W'(r_last_q[3]);
                    pdte_pkg::A_R00:  op_a = pdte_pkg::OPD_W'(r_rot[0]);
                    pdte_pkg::A_R01:  op_a = pdte_pkg::OPD_W'(r_rot[1]);
                    pdte_pkg::A_R02:  op_a = pdte_pkg::OPD_W'(r_rot[2]);
                    pdte_pkg::A_R10:  op_a = pdte_pkg::OPD_W'(r_rot[3]);
                    pdte_pkg::A_R11:  op_a = pdte_pkg::OPD_W'(r_rot[4]);
                    pdte_pkg::A_R12:  op_a = pdte_pkg::OPD_W'(r_rot[5]);
                    pdte_pkg::A_R20:  op_a = pdte_pkg::OPD_W'(r_rot[6]);
                    pdte_pkg::A_R21:  op_a = pdte_pkg::OPD_W'(r_rot[7]);
                    pdte_pkg::A_R22:  op_a = pdte_pkg::OPD_W'(r_rot[8]);
                    default:          op_a = '0;
                endcase
                unique case (u.bsel)
                    pdte_pkg::B_ZERO: op_b = '0;
                    pdte_pkg::B_ONE:  op_b = pdte_pkg::OPD_W'(pdte_pkg::Q_ONE);
                    pdte_pkg::B_W:    op_b = pdte_pkg::OPD_W'(r_q[0]);
                    pdte_pkg::B_X:    op_b = pdte_pkg::OPD_W'(r_q[1]);
                    pdte_pkg::B_Y:    op_b = pdte_pkg::OPD_W'(r_q[2]);
                    pdte_pkg::B_Z:    op_b = pdte_pkg::OPD_W'(r_q[3]);
                    pdte_pkg::B_D0:   op_b = pdte_pkg::OPD_W'(d[0]);
                    pdte_pkg::B_D1:   op_b = pdte_pkg::OPD_W'(d[1]);
                    pdte_pkg::B_D2:   op_b = pdte_pkg::OPD_W'(d[2]);
                    default:          op_b = '0;
                endcase
            end
            S_SCL_LO: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                op_a = signed'(pdte_pkg::OPD_W'(sel_mag[pdte_pkg::SPLIT-1:0]));
                op_b = signed'(sel_k);
            end
            S_SCL_HI: begin
                mac_ctl.en = 1'b1;
                mac_ctl.hi = 1'b1;
                op_a = signed'(pdte_pkg::OPD_W'(sel_mag[pdte_pkg::BV_W-1:pdte_pkg::SPLIT]));
                op_b = signed'(sel_k);
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    assign div_start = (r_state == S_DIV_GO);

    pdte_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (op_a),
        .i_b   (op_b),
        .o_acc (acc)
    );

    pdte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (acc),
        .i_den   (sel_den),
        .i_neg   (sel_neg),
        .o_sts   (div_sts),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min        <= pdte_pkg::MIN_RESET;
            r_last_pos   <= '{default: '0};
            r_last_q     <= '{pdte_pkg::Q_ONE, '0, '0, '0};
            r_last_stamp <= '0;
            r_have_prev  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_step       <= '0;
            r_k          <= '0;
        end else begin
            if (cfg_wr && !paddr[2]) begin
                r_min <= pwdata[pdte_pkg::MIN_W-1:0];
            end
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pos   <= '{i_pos_x, i_pos_y, i_pos_z};
                        r_q     <= '{i_quat_w, i_quat_x, i_quat_y, i_quat_z};
                        r_stamp <= i_stamp_ns;
                        r_dt    <= dt_in;
                        r_ok    <= ok_in;
                        r_step  <= '0;
                        r_k     <= '0;
                        r_state <= ok_in ? S_RUN : S_OUT;
                    end
                end
                S_RUN: begin
                    unique case (u.dst)
                        pdte_pkg::D_R00: r_rot[0] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_R01: r_rot[1] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_R02: r_rot[2] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_R10: r_rot[3] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_R11: r_rot[4] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_R12: r_rot[5] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_R20: r_rot[6] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_R21: r_rot[7] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_R22: r_rot[8] <= acc[pdte_pkg::ROT_W-1:0];
                        pdte_pkg::D_DQ0: r_dq[0]  <= acc[pdte_pkg::DQ_W-1:0];
                        pdte_pkg::D_DQ1: r_dq[1]  <= acc[pdte_pkg::DQ_W-1:0];
                        pdte_pkg::D_DQ2: r_dq[2]  <= acc[pdte_pkg::DQ_W-1:0];
                        pdte_pkg::D_DQ3: r_dq[3]  <= acc[pdte_pkg::DQ_W-1:0];
                        pdte_pkg::D_B0:  r_bv[0]  <= acc[pdte_pkg::BV_W-1:0];
                        pdte_pkg::D_B1:  r_bv[1]  <= acc[pdte_pkg::BV_W-1:0];
                        pdte_pkg::D_B2:  r_bv[2]  <= acc[pdte_pkg::BV_W-1:0];
                        default: ;
                    endcase
                    if (r_step == pdte_pkg::STEP_LAST) begin
                        r_state <= S_SCL_LO;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SCL_LO: r_state <= S_SCL_HI;
                S_SCL_HI: r_state <= S_DIV_GO;
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_sts.done) begin
                        r_res[r_k] <= div_res;
                        if (r_k == pdte_pkg::K_W'(pdte_pkg::N_OUT - 1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_SCL_LO;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_tw     <= r_ok;
                        for (int i = 0; i < pdte_pkg::N_OUT; i++) begin
                            r_out[i] <= r_ok ? r_res[i] : '0;
                        end
                        r_last_pos   <= r_pos;
                        r_last_q     <= r_q;
                        r_last_stamp <= r_stamp;
                        r_have_prev  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_twist_valid = r_out_tw;
    assign o_lin_vel_x   = r_out[0];
    assign o_lin_vel_y   = r_out[1];
    assign o_lin_vel_z   = r_out[2];
    assign o_ang_vel_x   = r_out[3];
    assign o_ang_vel_y   = r_out[4];
    assign o_ang_vel_z   = r_out[5];

    assign vel_bad = o_out_valid && !o_twist_valid
                     && (o_lin_vel_x != '0 || o_lin_vel_y != '0 || o_lin_vel_z != '0
                         || o_ang_vel_x != '0 || o_ang_vel_y != '0 || o_ang_vel_z != '0);

    `PDTE_ASSERT(a_zero_when_invalid, i_clk, i_rst_n, !vel_bad, "velocity nonzero on invalid twist")
    `PDTE_ASSERT(a_div_start_idle, i_clk, i_rst_n, div_start |-> !div_sts.busy, "divider busy at start")
    `PDTE_ASSERT(a_one_in_flight, i_clk, i_rst_n, in_acc |=> !o_in_ready, "two items in flight")

endmodule
`default_nettype wire

/* bench/pose_difference_twist_estimator_tb.sv */
// Self-checking testbench for the pose-difference twist estimator.
`timescale 1ns / 1ps
module pose_difference_twist_estimator_tb;
    import pdte_pkg::*;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic signed [POS_W-1:0]  pos [3];
        logic signed [QUAT_W-1:0] quat [4];
        logic [STAMP_W-1:0]       stamp;
    } pose_t;

    typedef struct {
        logic signed [VEL_W-1:0] vel [6];
        logic                    tv;
    } twist_t;

    class twist_scoreboard;
        longint last_pos [3];
        longint last_quat [4];
        logic [STAMP_W-1:0] last_stamp;
        bit have_prev;
        logic [MIN_W-1:0] min_ns;
        twist_t pending_twists [$];
        int mismatches;

        function void reset_state();
            foreach (last_pos[i]) last_pos[i] = 0;
            last_quat[0] = 16384;
            last_quat[1] = 0;
            last_quat[2] = 0;
            last_quat[3] = 0;
            last_stamp = '0;
            have_prev = 0;
            min_ns = MIN_RESET;
            mismatches = 0;
        endfunction

        function logic [31:0] div_round_sat(wide_t num, logic [159:0] den);
            logic [159:0] mag;
            logic [159:0] q;
            bit neg;
            neg = num < 0;
            mag = neg ? -num : num;
            q = (mag + (den >> 1)) / den;
            if (neg) return (q > 160'h8000_0000) ? VEL_MIN : 32'(-q);
            return (q > 160'h7FFF_FFFF) ? VEL_MAX : q[31:0];
        endfunction

        function void note_pose(pose_t p);
            twist_t t;
            longint w, x, y, z, dt;
            longint r [9];
            longint dq [4];
            longint d [3];
            wide_t b [3];
            for (int i = 0; i < 6; i++) t.vel[i] = '0;
            t.tv = 1'b0;
            if (have_prev && p.stamp > last_stamp && p.stamp - last_stamp > min_ns) begin
                w = p.quat[0]; x = p.quat[1]; y = p.quat[2]; z = p.quat[3];
                r[0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
                r[1] = 2 * (x * y - z * w);
                r[2] = 2 * (x * z + y * w);
                r[3] = 2 * (x * y + z * w);
                r[4] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
                r[5] = 2 * (y * z - x * w);
                r[6] = 2 * (x * z - y * w);
                r[7] = 2 * (y * z + x * w);
                r[8] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
                dq[0] = last_quat[0]*w + last_quat[1]*x + last_quat[2]*y + last_quat[3]*z;
                dq[1] = -last_quat[1]*w + last_quat[0]*x - last_quat[3]*y + last_quat[2]*z;
                dq[2] = -last_quat[2]*w + last_quat[3]*x + last_quat[0]*y - last_quat[1]*z;
                dq[3] = -last_quat[3]*w - last_quat[2]*x + last_quat[1]*y + last_quat[0]*z;
                if (dq[0] < 0)
                    for (int i = 0; i < 4; i++) dq[i] = -dq[i];
                for (int i = 0; i < 3; i++) d[i] = longint'(p.pos[i]) - last_pos[i];
                for (int i = 0; i < 3; i++)
                    b[i] = wide_t'(r[i]) * wide_t'(d[0]) + wide_t'(r[3+i]) * wide_t'(d[1])
                         + wide_t'(r[6+i]) * wide_t'(d[2]);
                dt = longint'(p.stamp - last_stamp);
                for (int i = 0; i < 3; i++) begin
                    t.vel[i] = div_round_sat(b[i] * wide_t'(1000000000),
                                             160'(dt) << LIN_SHIFT);
                    t.vel[3+i] = div_round_sat(wide_t'(dq[1+i]) * wide_t'(2000000000),
                                               160'(dt) << ANG_SHIFT);
                end
                t.tv = 1'b1;
            end
            for (int i = 0; i < 3; i++) last_pos[i] = p.pos[i];
            for (int i = 0; i < 4; i++) last_quat[i] = p.quat[i];
            last_stamp = p.stamp;
            have_prev = 1;
            pending_twists.push_back(t);
        endfunction

        function void check_twist(twist_t got);
            twist_t exp_t;
            bit bad;
            if (pending_twists.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected twist at %0t", $realtime);
                return;
            end
            exp_t = pending_twists.pop_front();
            bad = got.tv !== exp_t.tv;
            for (int i = 0; i < 6; i++) bad |= got.vel[i] !== exp_t.vel[i];
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"twist mismatch at %0t: exp %0d %0d %0d %0d %0d %0d v%0b,",
                              " got %0d %0d %0d %0d %0d %0d v%0b"},
                             $realtime, exp_t.vel[0], exp_t.vel[1], exp_t.vel[2],
                             exp_t.vel[3], exp_t.vel[4], exp_t.vel[5], exp_t.tv,
                             got.vel[0], got.vel[1], got.vel[2], got.vel[3],
                             got.vel[4], got.vel[5], got.tv);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic signed [POS_W-1:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic signed [QUAT_W-1:0] i_quat_w = 0, i_quat_x = 0, i_quat_y = 0, i_quat_z = 0;
    logic [STAMP_W-1:0] i_stamp_ns = 0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic signed [VEL_W-1:0] o_lin_vel_x, o_lin_vel_y, o_lin_vel_z;
    logic signed [VEL_W-1:0] o_ang_vel_x, o_ang_vel_y, o_ang_vel_z;
    logic o_twist_valid;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    pose_difference_twist_estimator uut (.*);

    twist_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic [STAMP_W-1:0] cur_stamp;
    logic signed [POS_W-1:0] cur_pos [3];

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        twist_t got;
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.vel[0] = o_lin_vel_x; got.vel[1] = o_lin_vel_y; got.vel[2] = o_lin_vel_z;
            got.vel[3] = o_ang_vel_x; got.vel[4] = o_ang_vel_y; got.vel[5] = o_ang_vel_z;
            got.tv = o_twist_valid;
            sb.check_twist(got);
        end
    end

    task automatic send_pose(pose_t p);
        i_in_valid <= 1'b1;
        i_pos_x <= p.pos[0]; i_pos_y <= p.pos[1]; i_pos_z <= p.pos[2];
        i_quat_w <= p.quat[0]; i_quat_x <= p.quat[1];
        i_quat_y <= p.quat[2]; i_quat_z <= p.quat[3];
        i_stamp_ns <= p.stamp;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pose(p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_twists.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0) sb.min_ns = data[MIN_W-1:0];
        @(posedge i_clk);
    endtask

    function automatic logic signed [QUAT_W-1:0] rand_q(int span);
        return QUAT_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic pose_t make_pose(logic [STAMP_W-1:0] st);
        pose_t p;
        int kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            if (kind < 85) cur_pos[i] = cur_pos[i] + POS_W'($urandom_range(0, 1 << 21))
                                        - POS_W'(1 << 20);
            else cur_pos[i] = $urandom;
            p.pos[i] = cur_pos[i];
        end
        if (kind < 60) begin
            p.quat[0] = QUAT_W'(16384 - $urandom_range(0, 3000));
            if ($urandom_range(0, 3) == 0) p.quat[0] = -p.quat[0];
            for (int i = 1; i < 4; i++) p.quat[i] = rand_q(4000);
        end else begin
            for (int i = 0; i < 4; i++) p.quat[i] = rand_q(16384);
        end
        p.stamp = st;
        return p;
    endfunction

    function automatic logic [STAMP_W-1:0] next_stamp();
        int kind;
        longint m;
        kind = $urandom_range(0, 99);
        m = longint'(sb.min_ns);
        if (kind < 70) return cur_stamp + STAMP_W'(m + 1 + $urandom_range(0, 3000));
        if (kind < 78) return cur_stamp + STAMP_W'(m);
        if (kind < 84) return cur_stamp + STAMP_W'(m + 1);
        if (kind < 88) return cur_stamp + STAMP_W'($urandom_range(0, 1000000));
        if (kind < 92) return cur_stamp - STAMP_W'($urandom_range(0, 5000));
        if (kind < 96) return cur_stamp + STAMP_W'({$urandom, $urandom} >> 32);
        return STAMP_W'({$urandom, $urandom} >> 16);
    endfunction

    initial begin
        pose_t p;
        logic [MIN_W-1:0] mins [8];
        sb.reset_state();
        foreach (cur_pos[i]) cur_pos[i] = 0;
        cur_stamp = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first sample, extremes, sign flip, short and backward intervals
        p.pos = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0};
        p.quat = '{16'sd16384, 0, 0, 0};
        p.stamp = 48'd100;
        send_pose(p);
        p.pos = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        p.stamp = 48'd1101;
        send_pose(p);
        p.quat = '{-16'sd16384, 0, 0, 0};
        p.stamp = 48'd2101;
        send_pose(p);
        p.quat = '{0, 16'sd16384, 0, 0};
        p.stamp = 48'd3102;
        send_pose(p);
        p.quat = '{0, 0, -16'sd16384, 0};
        p.stamp = 48'd3102;
        send_pose(p);
        p.quat = '{0, 0, 0, 16'sd16384};
        p.stamp = 48'd3000;
        send_pose(p);
        p.quat = '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384};
        p.stamp = 48'd4001;
        send_pose(p);
        p.quat = '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
        p.stamp = 48'd4002;
        send_pose(p);
        p.pos = '{0, 0, 0};
        p.quat = '{16'sd11585, 16'sd11585, 0, 0};
        p.stamp = 48'hFFFF_FFFF_0000;
        send_pose(p);
        p.pos = '{32'sh10000, -32'sh10000, 32'sh8000};
        p.stamp = 48'hFFFF_FFFF_FFFF;
        send_pose(p);
        p.stamp = 48'd0;
        send_pose(p);
        p.quat = '{16'sd16000, -16'sd300, 16'sd200, -16'sd100};
        p.stamp = 48'd1;
        send_pose(p);
        cur_stamp = 48'd1;
        drain();

        apb_write(3'd4, 32'd5);
        mins = '{20'd0, 20'd1000000, 20'd1000, 20'hFFFFF, 20'd1, 20'd50000, 20'd999999, 20'd0};
        mins[7] = MIN_W'($urandom_range(0, 1000000));
        for (int ph = 0; ph < 8; ph++) begin
            apb_write(3'd0, {12'h0, mins[ph]});
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int n = 0; n < 200; n++) begin
                if (ph == 2 && n == 100) begin
                    i_in_valid <= 1'b0;
                    while (sb.pending_twists.size() != 0) @(posedge i_clk);
                end
                cur_stamp = next_stamp();
                send_pose(make_pose(cur_stamp));
            end
            drain();
        end
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

/* pose_difference_twist_estimator.f */
+incdir+sv
sv/pdte_pkg.sv
sv/pdte_mac.sv
sv/pdte_div.sv
sv/pose_difference_twist_estimator.sv
bench/pose_difference_twist_estimator_tb.sv
